// ----- design/pgc_pkg.sv -----
// ============================================================================
// pgc_pkg: shared types and constants for the pairwise force pipeline
// Widths of the fixed-point intermediates and the side-band record that
// travels with every beat down the pipeline.
// ============================================================================
package pgc_pkg;

    localparam int AD_W   = 33;   // |pos_b - pos_a|
    localparam int R2_W   = 66;   // squared distance, Q32.32
    localparam int RT_W   = 33;   // distance, Q16.16
    localparam int SM_W   = 97;   // |S|, Q48.48
    localparam int DEN_W  = 99;   // R2 * r
    localparam int F_W    = 90;   // force term after the cap
    localparam int P_W    = 123;  // F * |d|
    localparam int DV_W   = 44;   // mass << 12
    localparam int SQ_N   = 33;   // root digits
    localparam int D1_N   = 90;   // force quotient bits
    localparam int D2_N   = 32;   // output quotient bits

    localparam logic [31:0] POS_SAT = 32'h7fff_ffff;
    localparam logic [31:0] MAG_SAT = 32'h8000_0000;

    typedef enum logic {
        REG_GRAV = 1'b0,
        REG_COUL = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][AD_W-1:0] ad;
        logic [2:0]           dneg;
        logic                 sneg;
        logic                 coll;
        logic [31:0]          mdiv_a;
        logic [31:0]          mdiv_b;
    } t_side;

    // divisor for quotient lane n: even lanes use mass a, odd lanes mass b
    function automatic logic [DV_W-1:0] f_divisor(t_side s, logic sel_b);
        logic [31:0] m;
        m = sel_b ? s.mdiv_b : s.mdiv_a;
        return {m, 12'b0};
    endfunction

endpackage

// ----- design/pgc_pair_if.sv -----
// ============================================================================
// pgc_pair_if: particle pair channel
// valid/ready handshake carrying the positions, masses, charges and radii.
// ============================================================================
interface pgc_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic        [31:0] mass_a;
    logic        [31:0] mass_b;
    logic signed [31:0] charge_a;
    logic signed [31:0] charge_b;
    logic        [31:0] radius_a;
    logic        [31:0] radius_b;

    modport source (
        output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               mass_a, mass_b, charge_a, charge_b, radius_a, radius_b,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               mass_a, mass_b, charge_a, charge_b, radius_a, radius_b,
        output ready
    );
endinterface

// ----- design/pgc_res_if.sv -----
// ============================================================================
// pgc_res_if: acceleration result channel
// valid/ready handshake carrying both acceleration increments and the flag.
// ============================================================================
interface pgc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] acc_a_x;
    logic signed [31:0] acc_a_y;
    logic signed [31:0] acc_a_z;
    logic signed [31:0] acc_b_x;
    logic signed [31:0] acc_b_y;
    logic signed [31:0] acc_b_z;
    logic               collided;

    modport source (
        output valid, acc_a_x, acc_a_y, acc_a_z, acc_b_x, acc_b_y, acc_b_z, collided,
        input  ready
    );
    modport sink (
        input  valid, acc_a_x, acc_a_y, acc_a_z, acc_b_x, acc_b_y, acc_b_z, collided,
        output ready
    );
endinterface

// ----- design/pairwise_gravity_coulomb_force.sv -----
// ============================================================================
// pairwise_gravity_coulomb_force: gravity + Coulomb pair force pipeline
// Per-pair acceleration increments in signed Q16.16, saturated, and a
// collision flag.
// ============================================================================
// Fully pipelined: one pair beat is taken every cycle. The depth is set by
// the bit-serial units laid out as stages: a 33-stage square root, a
// 90-stage divider for the force term and six 32-stage dividers (one per
// axis and particle) for the final quotient. The whole pipeline advances
// together; it halts only while the output register holds a beat the
// sink has not taken. The user writes constants over the APB port
// (grav_const at 0x0, coulomb_const at 0x4) only while idle; unenforced.
module pairwise_gravity_coulomb_force (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgc_pair_if.sink    i_pair,
    pgc_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pgc_pkg::*;

    // ---------------- configuration ----------------
    logic [31:0] r_grav, r_coul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= 32'h0001_0000;
            r_coul <= 32'h0001_0000;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_GRAV: r_grav <= pwdata;
                REG_COUL: r_coul <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_GRAV: prdata = r_grav;
                REG_COUL: prdata = r_coul;
                default:  prdata = '0;
            endcase
        end
    end
    assign pready = 1'b1;

    // ---------------- pipeline advance ----------------
    logic w_en;
    logic r_out_vld;
    assign w_en         = !r_out_vld || o_res.ready;
    assign i_pair.ready = w_en;

    // ---------------- A1: differences, magnitudes ----------------
    logic [2:0][AD_W-1:0] w_d;
    logic [2:0][31:0]     w_pa, w_pb;
    assign w_pa = {i_pair.pos_a_z, i_pair.pos_a_y, i_pair.pos_a_x};
    assign w_pb = {i_pair.pos_b_z, i_pair.pos_b_y, i_pair.pos_b_x};

    for (genvar k = 0; k < 3; k++) begin : g_diff
        assign w_d[k] = {w_pb[k][31], w_pb[k]} - {w_pa[k][31], w_pa[k]};
    end

    logic        r_a1_vld;
    t_side       r_a1_side;
    logic [31:0] r_a1_qa, r_a1_qb, r_a1_ma, r_a1_mb;
    logic        r_a1_cneg;
    logic [32:0] r_a1_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a1_vld <= 1'b0;
        else if (w_en) r_a1_vld <= i_pair.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a1_side.dneg[k] <= w_d[k][AD_W-1];
                r_a1_side.ad[k]   <= w_d[k][AD_W-1] ? (AD_W)'(-w_d[k]) : w_d[k];
            end
            r_a1_side.sneg   <= 1'b0;
            r_a1_side.coll   <= 1'b0;
            r_a1_side.mdiv_a <= (i_pair.mass_a == '0) ? 32'd1 : i_pair.mass_a;
            r_a1_side.mdiv_b <= (i_pair.mass_b == '0) ? 32'd1 : i_pair.mass_b;
            r_a1_qa   <= i_pair.charge_a[31] ? 32'(-i_pair.charge_a) : i_pair.charge_a;
            r_a1_qb   <= i_pair.charge_b[31] ? 32'(-i_pair.charge_b) : i_pair.charge_b;
            r_a1_cneg <= i_pair.charge_a[31] ^ i_pair.charge_b[31];
            r_a1_ma   <= i_pair.mass_a;
            r_a1_mb   <= i_pair.mass_b;
            r_a1_rsum <= {1'b0, i_pair.radius_a} + {1'b0, i_pair.radius_b};
        end
    end

    // ---------------- A2: squares and pair products ----------------
    logic                 r_a2_vld;
    t_side                r_a2_side;
    logic [2:0][R2_W-1:0] r_a2_sq;
    logic [63:0]          r_a2_mm, r_a2_qq;
    logic                 r_a2_cneg;
    logic [32:0]          r_a2_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a2_vld <= 1'b0;
        else if (w_en) r_a2_vld <= r_a1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++)
                r_a2_sq[k] <= (R2_W)'(r_a1_side.ad[k]) * (R2_W)'(r_a1_side.ad[k]);
            r_a2_mm   <= 64'(r_a1_ma) * 64'(r_a1_mb);
            r_a2_qq   <= 64'(r_a1_qa) * 64'(r_a1_qb);
            r_a2_side <= r_a1_side;
            r_a2_cneg <= r_a1_cneg;
            r_a2_rsum <= r_a1_rsum;
        end
    end

    // ---------------- A3: R2, radius square, constant partials ----------------
    logic [R2_W-1:0] w_r2sum;
    assign w_r2sum = r_a2_sq[0] + r_a2_sq[1] + r_a2_sq[2];

    logic            r_a3_vld;
    t_side           r_a3_side;
    logic [R2_W-1:0] r_a3_r2, r_a3_rs;
    logic [63:0]     r_a3_g_lo, r_a3_g_hi, r_a3_c_lo, r_a3_c_hi;
    logic            r_a3_cneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a3_vld <= 1'b0;
        else if (w_en) r_a3_vld <= r_a2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // zero distance is floored at one LSB
            r_a3_r2   <= (w_r2sum == '0) ? (R2_W)'(1) : w_r2sum;
            r_a3_rs   <= (R2_W)'(r_a2_rsum) * (R2_W)'(r_a2_rsum);
            r_a3_g_lo <= 64'(r_a2_mm[31:0])  * 64'(r_grav);
            r_a3_g_hi <= 64'(r_a2_mm[63:32]) * 64'(r_grav);
            r_a3_c_lo <= 64'(r_a2_qq[31:0])  * 64'(r_coul);
            r_a3_c_hi <= 64'(r_a2_qq[63:32]) * 64'(r_coul);
            r_a3_side <= r_a2_side;
            r_a3_cneg <= r_a2_cneg;
        end
    end

    // ---------------- A4: full gravity and Coulomb terms ----------------
    logic            r_a4_vld;
    t_side           r_a4_side;
    logic [R2_W-1:0] r_a4_r2;
    logic [95:0]     r_a4_grav, r_a4_coul;
    logic            r_a4_cneg;
    t_side           w_a4_side;

    always_comb begin
        w_a4_side      = r_a3_side;
        w_a4_side.coll = r_a3_r2 < r_a3_rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a4_vld <= 1'b0;
        else if (w_en) r_a4_vld <= r_a3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a4_grav <= {r_a3_g_hi, 32'b0} + {32'b0, r_a3_g_lo};
            r_a4_coul <= {r_a3_c_hi, 32'b0} + {32'b0, r_a3_c_lo};
            r_a4_r2   <= r_a3_r2;
            r_a4_cneg <= r_a3_cneg;
            r_a4_side <= w_a4_side;
        end
    end

    // ---------------- A5 = root stage 0: signed net strength ----------------
    logic              r_sq_vld  [0:SQ_N];
    t_side             r_sq_side [0:SQ_N];
    logic [SM_W-1:0]   r_sq_smag [0:SQ_N];
    logic [R2_W-1:0]   r_sq_r2   [0:SQ_N];
    logic [35:0]       r_sq_rem  [0:SQ_N];
    logic [RT_W-1:0]   r_sq_root [0:SQ_N];

    logic            w_c_ge_g;
    t_side           w_a5_side;
    logic [SM_W-1:0] w_a5_smag;
    assign w_c_ge_g = r_a4_coul >= r_a4_grav;

    always_comb begin
        w_a5_side = r_a4_side;
        if (r_a4_cneg) begin
            w_a5_smag      = {1'b0, r_a4_coul} + {1'b0, r_a4_grav};
            w_a5_side.sneg = 1'b1;
        end else if (w_c_ge_g) begin
            w_a5_smag      = {1'b0, r_a4_coul} - {1'b0, r_a4_grav};
            w_a5_side.sneg = 1'b0;
        end else begin
            w_a5_smag      = {1'b0, r_a4_grav} - {1'b0, r_a4_coul};
            w_a5_side.sneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_vld[0] <= 1'b0;
        else if (w_en) r_sq_vld[0] <= r_a4_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= w_a5_side;
            r_sq_smag[0] <= w_a5_smag;
            r_sq_r2[0]   <= r_a4_r2;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // ---------------- integer square root, one digit per stage ----------------
    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        logic [35:0] w_rs, w_trial;
        logic        w_ge;
        assign w_rs    = {r_sq_rem[j][33:0], r_sq_r2[j][R2_W-1-2*j -: 2]};
        assign w_trial = {1'b0, r_sq_root[j], 2'b01};
        assign w_ge    = w_rs >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_vld[j+1] <= 1'b0;
            else if (w_en) r_sq_vld[j+1] <= r_sq_vld[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[j+1] <= r_sq_side[j];
                r_sq_smag[j+1] <= r_sq_smag[j];
                r_sq_r2[j+1]   <= r_sq_r2[j];
                r_sq_rem[j+1]  <= w_ge ? (w_rs - w_trial) : w_rs;
                r_sq_root[j+1] <= {r_sq_root[j][RT_W-2:0], w_ge};
            end
        end
    end

    // ---------------- M1/M2: denominator R2 * r ----------------
    logic            r_m1_vld;
    t_side           r_m1_side;
    logic [SM_W-1:0] r_m1_smag;
    logic [65:0]     r_m1_p_lo, r_m1_p_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m1_vld <= 1'b0;
        else if (w_en) r_m1_vld <= r_sq_vld[SQ_N];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_p_lo <= 66'(r_sq_r2[SQ_N][32:0])  * 66'(r_sq_root[SQ_N]);
            r_m1_p_hi <= 66'(r_sq_r2[SQ_N][65:33]) * 66'(r_sq_root[SQ_N]);
            r_m1_side <= r_sq_side[SQ_N];
            r_m1_smag <= r_sq_smag[SQ_N];
        end
    end

    logic             r_m2_vld;
    t_side            r_m2_side;
    logic [SM_W-1:0]  r_m2_smag;
    logic [DEN_W-1:0] r_m2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m2_vld <= 1'b0;
        else if (w_en) r_m2_vld <= r_m1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_den  <= (DEN_W)'({r_m1_p_hi, 33'b0}) + (DEN_W)'(r_m1_p_lo);
            r_m2_side <= r_m1_side;
            r_m2_smag <= r_m1_smag;
        end
    end

    // ---------------- force quotient (|S| << 28) / den ----------------
    logic             r_d1_vld  [0:D1_N];
    t_side            r_d1_side [0:D1_N];
    logic [DEN_W-1:0] r_d1_den  [0:D1_N];
    logic [DEN_W-1:0] r_d1_rem  [0:D1_N];
    logic [F_W-1:0]   r_d1_num  [0:D1_N];
    logic [F_W-1:0]   r_d1_q    [0:D1_N];
    logic             r_d1_ovf  [0:D1_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d1_vld[0] <= 1'b0;
        else if (w_en) r_d1_vld[0] <= r_m2_vld;
    end

    // top bits of the shifted numerator at or above den: quotient past the cap
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_side[0] <= r_m2_side;
            r_d1_den[0]  <= r_m2_den;
            r_d1_ovf[0]  <= (DEN_W)'(r_m2_smag[96:62]) >= r_m2_den;
            r_d1_rem[0]  <= (DEN_W)'(r_m2_smag[96:62]);
            r_d1_num[0]  <= {r_m2_smag[61:0], 28'b0};
            r_d1_q[0]    <= '0;
        end
    end

    for (genvar j = 0; j < D1_N; j++) begin : g_div1
        logic [DEN_W:0] w_rs, w_diff;
        logic           w_ge;
        assign w_rs   = {r_d1_rem[j], r_d1_num[j][F_W-1]};
        assign w_diff = w_rs - {1'b0, r_d1_den[j]};
        assign w_ge   = w_rs >= {1'b0, r_d1_den[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d1_vld[j+1] <= 1'b0;
            else if (w_en) r_d1_vld[j+1] <= r_d1_vld[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1_side[j+1] <= r_d1_side[j];
                r_d1_den[j+1]  <= r_d1_den[j];
                r_d1_ovf[j+1]  <= r_d1_ovf[j];
                r_d1_rem[j+1]  <= w_ge ? w_diff[DEN_W-1:0] : w_rs[DEN_W-1:0];
                r_d1_num[j+1]  <= {r_d1_num[j][F_W-2:0], 1'b0};
                r_d1_q[j+1]    <= {r_d1_q[j][F_W-2:0], w_ge};
            end
        end
    end

    // ---------------- P1/P2: F * |d_k| ----------------
    logic [F_W-1:0] w_f;
    assign w_f = r_d1_ovf[D1_N] ? '1 : r_d1_q[D1_N];

    logic                  r_p1_vld;
    t_side                 r_p1_side;
    logic [2:0][2:0][62:0] r_p1_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_vld <= 1'b0;
        else if (w_en) r_p1_vld <= r_d1_vld[D1_N];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++)
                for (int c = 0; c < 3; c++)
                    r_p1_pp[k][c] <= 63'(w_f[30*c +: 30]) * 63'(r_d1_side[D1_N].ad[k]);
            r_p1_side <= r_d1_side[D1_N];
        end
    end

    logic                 r_p2_vld;
    t_side                r_p2_side;
    logic [2:0][P_W-1:0]  r_p2_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_vld <= 1'b0;
        else if (w_en) r_p2_vld <= r_p1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++)
                r_p2_p[k] <= (P_W)'(r_p1_pp[k][0])
                           + (P_W)'({r_p1_pp[k][1], 30'b0})
                           + (P_W)'({r_p1_pp[k][2], 60'b0});
            r_p2_side <= r_p1_side;
        end
    end

    // ---------------- six output quotients, lane 2k: mass a, 2k+1: mass b ----
    logic                  r_d2_vld  [0:D2_N];
    t_side                 r_d2_side [0:D2_N];
    logic [2:0][31:0]      r_d2_plo  [0:D2_N];
    logic [5:0][DV_W-1:0]  r_d2_rem  [0:D2_N];
    logic [5:0][31:0]      r_d2_q    [0:D2_N];
    logic [5:0]            r_d2_ovf  [0:D2_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d2_vld[0] <= 1'b0;
        else if (w_en) r_d2_vld[0] <= r_p2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_side[0] <= r_p2_side;
            for (int n = 0; n < 6; n++) begin
                r_d2_ovf[0][n] <= r_p2_p[n/2][P_W-1:32]
                                  >= (91)'(f_divisor(r_p2_side, n[0]));
                r_d2_rem[0][n] <= r_p2_p[n/2][75:32];
                r_d2_q[0][n]   <= '0;
            end
            for (int k = 0; k < 3; k++)
                r_d2_plo[0][k] <= r_p2_p[k][31:0];
        end
    end

    for (genvar j = 0; j < D2_N; j++) begin : g_div2
        logic [5:0][DV_W:0] w_rs;
        logic [5:0]         w_ge;

        for (genvar n = 0; n < 6; n++) begin : g_lane
            logic [DV_W:0] w_dv;
            assign w_dv    = {1'b0, f_divisor(r_d2_side[j], 1'(n % 2))};
            assign w_rs[n] = {r_d2_rem[j][n], r_d2_plo[j][n/2][31]};
            assign w_ge[n] = w_rs[n] >= w_dv;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_d2_rem[j+1][n] <= w_ge[n] ? (DV_W)'(w_rs[n] - w_dv)
                                                : w_rs[n][DV_W-1:0];
                    r_d2_q[j+1][n]   <= {r_d2_q[j][n][30:0], w_ge[n]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d2_vld[j+1] <= 1'b0;
            else if (w_en) r_d2_vld[j+1] <= r_d2_vld[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2_side[j+1] <= r_d2_side[j];
                r_d2_ovf[j+1]  <= r_d2_ovf[j];
                for (int k = 0; k < 3; k++)
                    r_d2_plo[j+1][k] <= {r_d2_plo[j][k][30:0], 1'b0};
            end
        end
    end

    // ---------------- output register: sign and saturation ----------------
    logic [5:0][31:0] w_res;
    t_side            w_fs;
    assign w_fs = r_d2_side[D2_N];

    always_comb begin
        logic [31:0] mag;
        logic        neg;
        for (int n = 0; n < 6; n++) begin
            mag = (r_d2_ovf[D2_N][n] || r_d2_q[D2_N][n] > MAG_SAT) ? MAG_SAT
                                                                  : r_d2_q[D2_N][n];
            // a is pushed opposite to b
            neg = w_fs.sneg ^ w_fs.dneg[n/2] ^ (n % 2 == 0);
            if (neg) w_res[n] = 32'(-mag);
            else     w_res[n] = mag[31] ? POS_SAT : mag;
        end
    end

    logic [5:0][31:0] r_out_acc;
    logic             r_out_coll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_en) r_out_vld <= r_d2_vld[D2_N];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_acc  <= w_res;
            r_out_coll <= w_fs.coll;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.acc_a_x  = r_out_acc[0];
    assign o_res.acc_b_x  = r_out_acc[1];
    assign o_res.acc_a_y  = r_out_acc[2];
    assign o_res.acc_b_y  = r_out_acc[3];
    assign o_res.acc_a_z  = r_out_acc[4];
    assign o_res.acc_b_z  = r_out_acc[5];
    assign o_res.collided = r_out_coll;

endmodule
